@@ rtl/spm_pkg.sv @@
// Package for the segment page mapper: sizes, codes, register indexes and map helpers.
package spm_pkg;

  // Store sizes.
  localparam int ROM_PAGES = 256;
  localparam int RAM_PAGES = 64;
  localparam int SEG_BYTES = 8192;
  localparam int ROM_BYTES = 16384;

  localparam int ADDR_W   = 16;
  localparam int OFS_W    = 13;
  localparam int SEG_W    = 3;
  localparam int PHYS_W   = 23;
  localparam int PAGE_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  // Byte address in main memory where the RAM pages start.
  localparam logic [PHYS_W-1:0] RAM_BASE = PHYS_W'(ROM_PAGES * ROM_BYTES);

  // Sideways RAM base pages.
  localparam logic [2:0] DOCK_HI = 3'b100;  // page 32 + segment
  localparam logic [2:0] EX_HI   = 3'b101;  // page 40 + segment

  // Target store codes.
  localparam logic [1:0] STORE_MAIN     = 2'd0;
  localparam logic [1:0] STORE_VRAM     = 2'd1;
  localparam logic [1:0] STORE_FAILSAFE = 2'd2;

  // Region type codes.
  localparam logic [1:0] REGION_ROM  = 2'd0;
  localparam logic [1:0] REGION_HOME = 2'd1;
  localparam logic [1:0] REGION_DOCK = 2'd2;
  localparam logic [1:0] REGION_EX   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BANK_PORT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLUS3_PORT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDEWAYS_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EX_SELECT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROM_PAGE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMPAT_128    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE      = 3'd6;

  typedef struct packed {
    logic [7:0] bank_port;
    logic [7:0] plus3_port;
    logic [7:0] sideways_mask;
    logic       ex_select;
    logic [7:0] rom_page;
    logic       compat_128;
    logic       failsafe;
  } spm_cfg_t;

  typedef struct packed {
    logic [1:0]        target_store;
    logic [PHYS_W-1:0] phys_address;
    logic [1:0]        region_type;
  } spm_result_t;

  // Table of ROM page numbers wrapped into the fitted ROM, built at elaboration.
  function automatic logic [255:0][7:0] rom_wrap_table();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(i % ROM_PAGES);
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] ROM_WRAP = rom_wrap_table();

  // 16 KB page of one slot in all-RAM mode.
  function automatic logic [2:0] page_set(input logic [1:0] set, input logic [1:0] slot);
    logic [2:0] p;
    case (set)
      2'd0:    p = {1'b0, slot};
      2'd1:    p = {1'b1, slot};
      2'd2:    p = (slot == 2'd3) ? 3'd3 : {1'b1, slot};
      default: begin
        case (slot)
          2'd0:    p = 3'd4;
          2'd1:    p = 3'd7;
          2'd2:    p = 3'd6;
          default: p = 3'd3;
        endcase
      end
    endcase
    return p;
  endfunction

  // Byte address of an 8 KB RAM page; pages past the fitted RAM wrap around.
  // Page numbers stay below 64, which is under twice the smallest RAM size.
  function automatic logic [PHYS_W-1:0] ram_addr(input logic [PAGE_W-1:0] page,
                                                input logic [OFS_W-1:0] ofs);
    logic [PAGE_W-1:0] p;
    p = (32'(page) >= RAM_PAGES) ? PAGE_W'(32'(page) - RAM_PAGES) : page;
    return RAM_BASE + PHYS_W'({p, ofs});
  endfunction

endpackage

@@ rtl/spm_map.sv @@
// Address translation logic: one CPU address to store, physical address and region.
module spm_map (
  input  spm_pkg::spm_cfg_t              cfg,
  input  logic [spm_pkg::ADDR_W-1:0]     cpu_address,
  output spm_pkg::spm_result_t           result
);

  logic [spm_pkg::SEG_W-1:0] seg;
  logic [spm_pkg::OFS_W-1:0] ofs;
  logic [4:0]                bank;
  logic [2:0]                set_page;
  logic [7:0]                rom_p;

  assign seg = cpu_address[15:13];
  assign ofs = cpu_address[spm_pkg::OFS_W-1:0];
  assign bank = {(cfg.compat_128 ? 2'b00 : cfg.bank_port[7:6]), cfg.bank_port[2:0]};
  assign set_page = spm_pkg::page_set(cfg.plus3_port[2:1], seg[2:1]);
  assign rom_p = spm_pkg::ROM_WRAP[cfg.rom_page];

  always_comb begin
    result.target_store = spm_pkg::STORE_MAIN;
    result.region_type  = spm_pkg::REGION_HOME;
    result.phys_address = '0;
    if (cfg.plus3_port[0]) begin
      result.phys_address = spm_pkg::ram_addr({2'b00, set_page, seg[0]}, ofs);
    end else begin
      case (seg[2:1])
        2'd0: begin
          result.phys_address = spm_pkg::PHYS_W'({rom_p, seg[0], ofs});
          result.region_type  = spm_pkg::REGION_ROM;
        end
        2'd1: result.phys_address = spm_pkg::ram_addr({5'd5, seg[0]}, ofs);
        2'd2: result.phys_address = spm_pkg::ram_addr({5'd2, seg[0]}, ofs);
        default: begin
          if (bank == 5'd5 || bank == 5'd7) begin
            // Banked pages 5 and 7 live in video RAM.
            result.target_store = spm_pkg::STORE_VRAM;
            result.phys_address = spm_pkg::PHYS_W'({bank[1], seg[0], ofs});
          end else begin
            result.phys_address = spm_pkg::ram_addr({bank, seg[0]}, ofs);
          end
        end
      endcase

      if (cfg.sideways_mask[seg]) begin
        result.target_store = spm_pkg::STORE_MAIN;
        if (cfg.ex_select) begin
          result.phys_address = spm_pkg::ram_addr({spm_pkg::EX_HI, seg}, ofs);
          result.region_type  = spm_pkg::REGION_EX;
        end else begin
          result.phys_address = spm_pkg::ram_addr({spm_pkg::DOCK_HI, seg}, ofs);
          result.region_type  = spm_pkg::REGION_DOCK;
        end
      end

      if (cfg.failsafe && seg[2:1] == 2'd0) begin
        result.target_store = spm_pkg::STORE_FAILSAFE;
        result.phys_address = spm_pkg::PHYS_W'({seg[0], ofs});
        result.region_type  = spm_pkg::REGION_ROM;
      end
    end
  end

endmodule

@@ rtl/segment_page_mapper_core.sv @@
// Top level of the segment page mapper: config registers, input stage and result stage.
//
//  Channel   Direction  Handshake              Word
//  in_       input      in_valid / in_ready    cpu_address
//  out_      output     out_valid / out_ready  target_store, phys_address, region_type
//  cfg_      input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// Each word is held in the input register and then moves to the result register, from
// which its result is offered on out_; while out_ready stays high, one word per cycle
// flows through. The translation is combinational logic over the config registers.
// Reset (synchronous, active low) empties both stages and clears every config register.
// When the result side stalls, the input register still takes one more word, so the
// two registers together act as a skid buffer.
module segment_page_mapper_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [spm_pkg::ADDR_W-1:0]      in_cpu_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_target_store,
  output logic [spm_pkg::PHYS_W-1:0]      out_phys_address,
  output logic [1:0]                      out_region_type,
  input  logic                            cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spm_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  spm_pkg::spm_cfg_t    cfg_r;
  spm_pkg::spm_result_t map_res;
  spm_pkg::spm_result_t res_r;

  logic                        in_valid_r;
  logic [spm_pkg::ADDR_W-1:0]  addr_r;
  logic                        out_valid_r;
  logic                        res_load;
  logic                        in_take;

  // The result register loads whenever it is empty or being drained.
  assign res_load = !out_valid_r || out_ready;
  // The input register takes a word when empty or when it hands its word on.
  assign in_ready = !in_valid_r || res_load;
  assign in_take  = in_valid && in_ready;

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spm_pkg::REG_BANK_PORT:     cfg_r.bank_port     <= cfg_wdata;
        spm_pkg::REG_PLUS3_PORT:    cfg_r.plus3_port    <= cfg_wdata;
        spm_pkg::REG_SIDEWAYS_MASK: cfg_r.sideways_mask <= cfg_wdata;
        spm_pkg::REG_EX_SELECT:     cfg_r.ex_select     <= cfg_wdata[0];
        spm_pkg::REG_ROM_PAGE:      cfg_r.rom_page      <= cfg_wdata;
        spm_pkg::REG_COMPAT_128:    cfg_r.compat_128    <= cfg_wdata[0];
        spm_pkg::REG_FAILSAFE:      cfg_r.failsafe      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      addr_r <= in_cpu_address;
    end
  end

  spm_map u_map (
    .cfg         (cfg_r),
    .cpu_address (addr_r),
    .result      (map_res)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && in_valid_r) begin
      res_r <= map_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_store = res_r.target_store;
  assign out_phys_address = res_r.phys_address;
  assign out_region_type  = res_r.region_type;

endmodule
